// ----- hdl/assert_macros.svh -----
// assertion macros used by the rtl file of the id set table
// no dependencies; define NO_ASSERTIONS to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property that must hold at every edge outside reset
`define IST_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// consequence that must hold at the edge after the antecedent
`define IST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define IST_ASSERT(lbl, clk, rst, prop, msg)
`define IST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/ist_pkg.sv -----
// shared types and codes of the id set table
// no dependencies; used by the channel interfaces and the top level
package ist_pkg;

   localparam int IDENT_W = 32;
   localparam int POS_W   = 4;
   localparam int COUNT_W = 5;

   typedef logic signed [IDENT_W-1:0] ident_type;
   typedef logic [POS_W-1:0]          position_type;
   typedef logic [COUNT_W-1:0]        count_type;

   // operation codes carried by a request beat
   typedef enum logic [1:0] {
      KIND_ADD    = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_CHECK  = 2'd2,
      KIND_READ   = 2'd3
   } kind_type;

   // value returned for a read beyond the count
   localparam ident_type EMPTY_MARK = '1;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_SCAN,
      ST_SHIFT,
      ST_RESP
   } state_type;

endpackage

// ----- hdl/ist_req_if.sv -----
// request channel of the id set table: valid/ready plus the operation payload
// depends on ist_pkg
interface ist_req_if;
   import ist_pkg::*;

   logic         valid;
   logic         ready;
   kind_type     kind;
   ident_type    ident;
   position_type position;

   modport source (output valid, kind, ident, position, input ready);
   modport sink   (input valid, kind, ident, position, output ready);
endinterface

// ----- hdl/ist_rsp_if.sv -----
// response channel of the id set table: valid/ready plus the result payload
// depends on ist_pkg
interface ist_rsp_if;
   import ist_pkg::*;

   logic      valid;
   logic      ready;
   logic      ok;
   ident_type ident_out;
   count_type count;

   modport source (output valid, ok, ident_out, count, input ready);
   modport sink   (input valid, ok, ident_out, count, output ready);
endinterface

// ----- hdl/id_set_table.sv -----
// Set of non-negative 32-bit identifiers held packed in a one-port-read table
// memory with a fill count. One request beat at a time; each gives one response
// beat carrying the count after the operation. Timing is set by the single
// read port of the table memory, which a sequencer walks one entry a cycle:
// a read at a position reads the table on acceptance, registers the entry and
// then loads the response; add and check scan all held entries (stopping early
// when a match is found); delete scans up to the match, then moves each later
// entry down one slot. A negative identifier or a read beyond the count goes
// straight to the response. The next request is taken once the response is in
// the output register, even if not yet taken.
// No clearing pass after reset: slots at or beyond the count are never used.
// depends on ist_pkg, ist_req_if, ist_rsp_if and assert_macros.svh
`include "assert_macros.svh"

module id_set_table #(
   parameter int CAPACITY = 16
) (
   input  logic      clock,
   input  logic      reset,
   ist_req_if.sink   req_bus,
   ist_rsp_if.source rsp_bus
);
   import ist_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = (CW > POS_W) ? CW : POS_W;
   localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

   // sequencer and operation registers
   state_type       state_ff, state_in;
   kind_type        kind_ff;
   ident_type       ident_ff;
   logic [CW-1:0]   fill_ff, fill_in;
   logic [CW-1:0]   idx_ff, idx_in;
   logic [CW-1:0]   cmp_idx_ff, cmp_idx_in;
   logic            cmp_valid_ff, cmp_valid_in;
   logic            res_ok_ff, res_ok_in;
   ident_type       res_val_ff, res_val_in;

   // output register
   logic            rsp_valid_ff, rsp_valid_in;
   logic            rsp_ok_ff;
   ident_type       rsp_ident_ff;
   count_type       rsp_count_ff;

   // table memory
   ident_type       mem [CAPACITY];
   ident_type       rdata_ff;
   logic [AW-1:0]   rd_addr;
   logic [AW-1:0]   wr_addr;
   ident_type       wr_data;
   logic            mem_we;

   logic            accept;
   logic            in_range;
   logic            negative;
   logic            issue_more;
   logic            hit;
   logic            rsp_load;
   logic            shift_done;
   logic            shift_wr;
   logic [CW-1:0]   prev_idx;

   assign accept     = req_bus.valid && req_bus.ready;
   assign in_range   = PW'(req_bus.position) < PW'(fill_ff);
   assign negative   = req_bus.ident[IDENT_W-1];
   assign issue_more = idx_ff < fill_ff;
   assign hit        = cmp_valid_ff && (rdata_ff == ident_ff);
   assign rsp_load   = (state_ff == ST_RESP) && (!rsp_valid_ff || rsp_bus.ready);
   assign shift_done = (state_ff == ST_SHIFT) && !issue_more;
   assign shift_wr   = (state_ff == ST_SHIFT) && mem_we;
   assign prev_idx   = cmp_idx_ff - CW'(1);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_bus.kind == KIND_READ) begin
                  state_in = in_range ? ST_READ : ST_RESP;
               end else if (negative) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_SCAN: begin
            if (hit) begin
               state_in = (kind_ff == KIND_DELETE) ? ST_SHIFT : ST_RESP;
            end else if (!issue_more) begin
               state_in = ST_RESP;
            end
         end
         ST_SHIFT: begin
            if (!issue_more) begin
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // handshake outputs
   always_comb begin
      req_bus.ready     = (state_ff == ST_IDLE);
      rsp_bus.valid     = rsp_valid_ff;
      rsp_bus.ok        = rsp_ok_ff;
      rsp_bus.ident_out = rsp_ident_ff;
      rsp_bus.count     = rsp_count_ff;
   end

   // scan, shift and memory port control
   always_comb begin
      fill_in      = fill_ff;
      idx_in       = idx_ff;
      cmp_idx_in   = cmp_idx_ff;
      cmp_valid_in = 1'b0;
      res_ok_in    = res_ok_ff;
      res_val_in   = res_val_ff;
      rd_addr      = idx_ff[AW-1:0];
      wr_addr      = fill_ff[AW-1:0];
      wr_data      = ident_ff;
      mem_we       = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               idx_in     = '0;
               res_ok_in  = 1'b0;
               res_val_in = '0;
               if (req_bus.kind == KIND_READ) begin
                  rd_addr = AW'(req_bus.position);
                  if (in_range) begin
                     res_ok_in = 1'b1;
                  end else begin
                     res_val_in = EMPTY_MARK;
                  end
               end
            end
         end
         ST_READ: begin
            res_val_in = rdata_ff;
         end
         ST_SCAN: begin
            // read one entry a cycle, compare the one read last cycle
            cmp_valid_in = issue_more;
            cmp_idx_in   = idx_ff;
            if (issue_more) begin
               idx_in = idx_ff + CW'(1);
            end
            if (hit) begin
               cmp_valid_in = 1'b0;
               res_ok_in    = 1'b1;
               idx_in       = cmp_idx_ff + CW'(1);
            end else if (!issue_more) begin
               // no match: append for add when there is room
               if ((kind_ff == KIND_ADD) && (fill_ff < CAP_CNT)) begin
                  mem_we    = 1'b1;
                  fill_in   = fill_ff + CW'(1);
                  res_ok_in = 1'b1;
               end else begin
                  res_ok_in = 1'b0;
               end
            end
         end
         ST_SHIFT: begin
            // read entry j, write it to j-1 on the next cycle
            cmp_valid_in = issue_more;
            cmp_idx_in   = idx_ff;
            if (issue_more) begin
               idx_in = idx_ff + CW'(1);
            end
            if (cmp_valid_ff) begin
               mem_we  = 1'b1;
               wr_addr = prev_idx[AW-1:0];
               wr_data = rdata_ff;
            end
            // the vacated top slot is beyond the count and never used
            if (!issue_more) begin
               fill_in = fill_ff - CW'(1);
            end
         end
         ST_RESP: begin
         end
         default: begin
         end
      endcase
   end

   // output register next valid
   always_comb begin
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      cmp_idx_ff <= cmp_idx_in;
      res_ok_ff  <= res_ok_in;
      res_val_ff <= res_val_in;
      if (accept) begin
         kind_ff  <= req_bus.kind;
         ident_ff <= req_bus.ident;
      end
      if (rsp_load) begin
         rsp_ok_ff    <= res_ok_ff;
         rsp_ident_ff <= res_val_ff;
         rsp_count_ff <= COUNT_W'(fill_ff);
      end
   end

   // table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[wr_addr] <= wr_data;
      end
      rdata_ff <= mem[rd_addr];
   end

   // checks
   `IST_ASSERT(a_fill_bound, clock, reset, fill_ff <= CAP_CNT, "fill above capacity")
   `IST_ASSERT(a_hit_held, clock, reset, hit |-> (cmp_idx_ff < fill_ff), "match beyond count")
   `IST_ASSERT(a_shift_addr, clock, reset, shift_wr |-> (cmp_idx_ff < fill_ff), "shift range")
   `IST_ASSERT_NEXT(a_accept_busy, clock, reset, accept, state_ff != ST_IDLE, "idle after accept")
   `IST_ASSERT_NEXT(a_del_count, clock, reset, shift_done, $past(fill_ff) == fill_ff + CW'(1), "count")

endmodule
